[sv/psms_pkg.sv]
// psms_pkg: types, constants and move table for the paired stepper move sequencer
// no dependencies; imported by the interfaces and every module of the block

package psms_pkg;

    localparam int NUM_MOTORS   = 6;
    localparam int TICKS_PER_MS = 1000;

    localparam int HALF_W   = 16;
    localparam int GAP_W    = 16;
    localparam int PRESC_W  = 10;
    localparam int STEPS_W  = 7;
    localparam int MOTOR_W  = 3;
    localparam int IDX_W    = 5;
    localparam int CODE_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [CODE_W-1:0]  LETTER_FIRST = 8'h41;   // 'A'
    localparam logic [CODE_W-1:0]  LETTER_LAST  = 8'h52;   // 'R'
    localparam logic [STEPS_W-1:0] STEPS_SHORT  = 7'd50;
    localparam logic [STEPS_W-1:0] STEPS_LONG   = 7'd100;
    localparam logic [PRESC_W-1:0] PRESC_LIMIT  = PRESC_W'(TICKS_PER_MS);

    localparam logic [HALF_W-1:0] HALF_RESET = 16'd1000;
    localparam logic [GAP_W-1:0]  GAP_RESET  = 16'd10;

    typedef logic [NUM_MOTORS-1:0] t_motor_vec;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2,
        PH_GAP  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_LETTER = 2'd1,
        MODE_END    = 2'd2,
        MODE_RSVD   = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HALF_PERIOD = 2'd0,
        CFG_MOVE_GAP    = 2'd1
    } t_cfg_idx;

    typedef struct packed {
        logic [HALF_W-1:0] half_period;
        logic [GAP_W-1:0]  move_gap;
    } t_cfg;

    typedef struct packed {
        logic               pending_valid;
        logic [IDX_W-1:0]   pending_move;
        t_phase             phase;
        logic [MOTOR_W-1:0] first_motor;
        logic [MOTOR_W-1:0] second_motor;
        logic               pair_active;
        logic [STEPS_W-1:0] first_steps;
        logic [STEPS_W-1:0] second_steps;
        logic [STEPS_W-1:0] step_index;
        t_motor_vec         direction_lines;
        logic [HALF_W-1:0]  half_tick_count;
        logic [PRESC_W-1:0] ms_prescale;
        logic [GAP_W-1:0]   gap_ms_count;
    } t_state;

    typedef struct packed {
        t_motor_vec step_pins;
        t_motor_vec dir_pins;
        t_motor_vec enable_n_pins;
        logic       busy_res;
        logic       accepted;
        logic       pair_pending;
        logic       move_done;
    } t_result;

    typedef struct packed {
        logic [MOTOR_W-1:0] motor;
        logic               dir;
        logic [STEPS_W-1:0] steps;
    } t_move;

    // motor of each group of three letters: U, D, L, R, F, B
    localparam logic [MOTOR_W-1:0] GROUP_MOTOR [6] = '{3'd0, 3'd3, 3'd4, 3'd1, 3'd2, 3'd5};

    function automatic t_move move_lookup(input logic [IDX_W-1:0] idx);
        logic [2:0]       grp;
        logic [IDX_W-1:0] sub;
        t_move            mv;
        case (idx)
            5'd0, 5'd1, 5'd2:    grp = 3'd0;
            5'd3, 5'd4, 5'd5:    grp = 3'd1;
            5'd6, 5'd7, 5'd8:    grp = 3'd2;
            5'd9, 5'd10, 5'd11:  grp = 3'd3;
            5'd12, 5'd13, 5'd14: grp = 3'd4;
            5'd15, 5'd16, 5'd17: grp = 3'd5;
            default:             grp = 3'd0;
        endcase
        sub      = idx - IDX_W'({2'b00, grp} * 5'd3);
        mv.motor = GROUP_MOTOR[grp];
        mv.dir   = (sub[1:0] == 2'd1);
        mv.steps = (sub[1:0] == 2'd2) ? STEPS_LONG : STEPS_SHORT;
        return mv;
    endfunction

    // axis of a motor: U/D, R/L and F/B share one
    function automatic logic [1:0] motor_axis(input logic [MOTOR_W-1:0] m);
        logic [MOTOR_W-1:0] r;
        r = (m >= 3'd3) ? m - 3'd3 : m;
        return r[1:0];
    endfunction

    function automatic logic is_opposite(input logic [MOTOR_W-1:0] ma,
                                         input logic [MOTOR_W-1:0] mb);
        return (ma != mb) && (motor_axis(ma) == motor_axis(mb));
    endfunction

endpackage

[sv/psms_if.sv]
// psms_if: valid/ready channel interfaces for moves, results and configuration
// depends on psms_pkg

interface psms_move_if;
    import psms_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic [CODE_W-1:0] move_code;

    modport source (output valid, output mode, output move_code, input ready);
    modport sink   (input valid, input mode, input move_code, output ready);
endinterface

interface psms_res_if;
    import psms_pkg::*;
    logic       valid;
    logic       ready;
    t_motor_vec step_pins;
    t_motor_vec dir_pins;
    t_motor_vec enable_n_pins;
    logic       busy_res;
    logic       accepted;
    logic       pair_pending;
    logic       move_done;

    modport source (output valid, output step_pins, output dir_pins, output enable_n_pins,
                    output busy_res, output accepted, output pair_pending,
                    output move_done, input ready);
    modport sink   (input valid, input step_pins, input dir_pins, input enable_n_pins,
                    input busy_res, input accepted, input pair_pending,
                    input move_done, output ready);
endinterface

interface psms_cfg_if;
    import psms_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/psms_cfg_regs.sv]
// psms_cfg_regs: step half period and move gap registers behind the write channel
// depends on psms_pkg and psms_cfg_if

module psms_cfg_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    psms_cfg_if.sink           i_cfg,
    output psms_pkg::t_cfg     o_cfg
);
    import psms_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_HALF_PERIOD: n_cfg.half_period = HALF_W'(i_cfg.data);
                CFG_MOVE_GAP:    n_cfg.move_gap    = GAP_W'(i_cfg.data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_period <= HALF_RESET;
            r_cfg.move_gap    <= GAP_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[sv/psms_next.sv]
// psms_next: next sequencer state and result for one beat
// depends on psms_pkg; purely combinational

module psms_next (
    input  psms_pkg::t_state           i_state,
    input  psms_pkg::t_cfg             i_cfg,
    input  logic [1:0]                 i_mode,
    input  logic [psms_pkg::CODE_W-1:0] i_code,
    output psms_pkg::t_state           o_state,
    output psms_pkg::t_result          o_res
);
    import psms_pkg::*;

    t_state             n;
    logic               busy;
    logic               accepted;
    logic               done;
    logic               do_start;
    logic               paired;
    logic               letter_ok;
    logic [IDX_W-1:0]   idx;
    t_move              mv_a;
    t_move              mv_b;
    logic [HALF_W-1:0]  hc_inc;
    logic [STEPS_W-1:0] si_inc;
    logic [STEPS_W-1:0] max_steps;
    logic [PRESC_W-1:0] ps_inc;
    logic [GAP_W-1:0]   gc_new;
    t_motor_vec         step_v;
    t_motor_vec         en_v;

    assign letter_ok = i_code inside {[LETTER_FIRST:LETTER_LAST]};
    assign idx       = IDX_W'(i_code - LETTER_FIRST);
    assign mv_a      = move_lookup(i_state.pending_move);
    assign mv_b      = move_lookup(idx);
    assign hc_inc    = i_state.half_tick_count + HALF_W'(1);
    assign si_inc    = i_state.step_index + STEPS_W'(1);
    assign ps_inc    = i_state.ms_prescale + PRESC_W'(1);
    assign max_steps = (i_state.pair_active && i_state.second_steps > i_state.first_steps)
                       ? i_state.second_steps : i_state.first_steps;

    always_comb begin
        n        = i_state;
        busy     = (i_state.phase != PH_IDLE);
        accepted = 1'b0;
        done     = 1'b0;
        do_start = 1'b0;
        paired   = 1'b0;
        gc_new   = i_state.gap_ms_count;

        case (t_mode'(i_mode))
            MODE_TICK: begin
                case (i_state.phase)
                    PH_HIGH: begin
                        if (hc_inc >= i_cfg.half_period) begin
                            n.half_tick_count = '0;
                            n.phase           = PH_LOW;
                        end else begin
                            n.half_tick_count = hc_inc;
                        end
                    end
                    PH_LOW: begin
                        if (hc_inc >= i_cfg.half_period) begin
                            n.half_tick_count = '0;
                            n.step_index      = si_inc;
                            if (si_inc >= max_steps) begin
                                n.ms_prescale  = '0;
                                n.gap_ms_count = '0;
                                if (i_cfg.move_gap == '0) begin
                                    n.phase = PH_IDLE;
                                    done    = 1'b1;
                                end else begin
                                    n.phase = PH_GAP;
                                end
                            end else begin
                                n.phase = PH_HIGH;
                            end
                        end else begin
                            n.half_tick_count = hc_inc;
                        end
                    end
                    PH_GAP: begin
                        if (ps_inc >= PRESC_LIMIT) begin
                            n.ms_prescale = '0;
                            gc_new        = i_state.gap_ms_count + GAP_W'(1);
                        end else begin
                            n.ms_prescale = ps_inc;
                        end
                        n.gap_ms_count = gc_new;
                        if (gc_new >= i_cfg.move_gap) begin
                            n.phase = PH_IDLE;
                            done    = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            MODE_LETTER: begin
                if (!busy) begin
                    accepted = 1'b1;
                    if (letter_ok) begin
                        if (i_state.pending_valid) begin
                            do_start = 1'b1;
                            if (is_opposite(mv_a.motor, mv_b.motor)) begin
                                paired          = 1'b1;
                                n.pending_valid = 1'b0;
                            end else begin
                                n.pending_move = idx;
                            end
                        end else begin
                            n.pending_valid = 1'b1;
                            n.pending_move  = idx;
                        end
                    end else if (i_state.pending_valid) begin
                        // a bad letter flushes the pending move alone
                        do_start        = 1'b1;
                        n.pending_valid = 1'b0;
                    end
                end
            end
            MODE_END: begin
                if (!busy) begin
                    accepted = 1'b1;
                    if (i_state.pending_valid) begin
                        do_start        = 1'b1;
                        n.pending_valid = 1'b0;
                    end
                end
            end
            default: ;
        endcase

        if (do_start) begin
            n.first_motor                  = mv_a.motor;
            n.first_steps                  = mv_a.steps;
            n.direction_lines[mv_a.motor]  = mv_a.dir;
            n.pair_active                  = paired;
            if (paired) begin
                n.second_motor                 = mv_b.motor;
                n.second_steps                 = mv_b.steps;
                n.direction_lines[mv_b.motor]  = mv_b.dir;
            end else begin
                n.second_motor = '0;
                n.second_steps = '0;
            end
            n.step_index      = '0;
            n.half_tick_count = '0;
            n.phase           = PH_HIGH;
        end

        step_v = '0;
        en_v   = '1;
        if (n.phase == PH_HIGH || n.phase == PH_LOW) begin
            en_v[n.first_motor] = 1'b0;
            if (n.pair_active) en_v[n.second_motor] = 1'b0;
            if (n.phase == PH_HIGH) begin
                if (n.step_index < n.first_steps) step_v[n.first_motor] = 1'b1;
                if (n.pair_active && n.step_index < n.second_steps)
                    step_v[n.second_motor] = 1'b1;
            end
        end
    end

    assign o_state             = n;
    assign o_res.step_pins     = step_v;
    assign o_res.dir_pins      = n.direction_lines;
    assign o_res.enable_n_pins = en_v;
    assign o_res.busy_res      = (n.phase != PH_IDLE);
    assign o_res.accepted      = accepted;
    assign o_res.pair_pending  = n.pending_valid;
    assign o_res.move_done     = done;

endmodule

[sv/paired_stepper_move_sequencer.sv]
// paired_stepper_move_sequencer: top level, state register and result register
// depends on psms_pkg, psms_if, psms_cfg_regs and psms_next
//
//  channel   dir  payload                                          beat when
//  i_move    in   mode, move_code                                  valid & ready
//  o_res     out  step/dir/enable_n pins, busy, accepted,          valid & ready
//                 pair_pending, move_done
//  i_cfg     in   index, data                                      valid & ready
//
// one beat per cycle while i_move.ready is high: each move beat updates the state register and loads the
// result register in the same cycle, so the result appears on o_res in the cycle after the beat
// i_move.ready drops only while a result waits and o_res.ready is low
// i_cfg is always ready; writes land at once
// reset (synchronous, active low) clears state and the result valid and loads the config reset values

module paired_stepper_move_sequencer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    psms_move_if.sink  i_move,
    psms_res_if.source o_res,
    psms_cfg_if.sink   i_cfg
);
    import psms_pkg::*;

    t_cfg    w_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result r_res;
    t_result n_res;
    logic    r_out_valid;
    logic    in_fire;

    psms_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    psms_next u_next (
        .i_state (r_state),
        .i_cfg   (w_cfg),
        .i_mode  (i_move.mode),
        .i_code  (i_move.move_code),
        .o_state (n_state),
        .o_res   (n_res)
    );

    assign i_move.ready = !r_out_valid || o_res.ready;
    assign in_fire      = i_move.valid && i_move.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) r_res <= n_res;
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.step_pins     = r_res.step_pins;
    assign o_res.dir_pins      = r_res.dir_pins;
    assign o_res.enable_n_pins = r_res.enable_n_pins;
    assign o_res.busy_res      = r_res.busy_res;
    assign o_res.accepted      = r_res.accepted;
    assign o_res.pair_pending  = r_res.pair_pending;
    assign o_res.move_done     = r_res.move_done;

    // motors are only enabled while busy
    a_enable_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_res.busy_res) |-> (r_res.enable_n_pins == '1))
        else $error("motor enabled while idle");

    // a step line only rises on an enabled motor
    a_step_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_res.step_pins & r_res.enable_n_pins) == '0))
        else $error("step on a disabled motor");

    // a move end leaves the block idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.move_done) |-> !r_res.busy_res)
        else $error("move_done while busy");

    // a letter refused while busy leaves the pending move alone
    a_refuse_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_state.phase != PH_IDLE && i_move.mode == MODE_LETTER)
        |=> ($stable(r_state.pending_valid) && $stable(r_state.pending_move)))
        else $error("busy letter changed pending move");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// testbench for paired_stepper_move_sequencer: directed moves, then random move beat streams
// depends on psms_pkg, psms_if and the block's rtl; the pin predictor lives in a small class

module testbench;
    import psms_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    logic i_clk;
    logic i_rst_n;

    psms_move_if mv_if ();
    psms_res_if  res_if ();
    psms_cfg_if  cfg_if ();

    paired_stepper_move_sequencer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_move  (mv_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // predicts the pin frame for every move beat and checks the frames that come back
    class pin_scoreboard;
        logic [HALF_W-1:0]  half_period;
        logic [GAP_W-1:0]   move_gap;
        logic               pend_valid;
        logic [IDX_W-1:0]   pend_move;
        t_phase             phase;
        logic [MOTOR_W-1:0] motor_a;
        logic [MOTOR_W-1:0] motor_b;
        logic               paired;
        logic [STEPS_W-1:0] steps_a;
        logic [STEPS_W-1:0] steps_b;
        logic [STEPS_W-1:0] step_idx;
        t_motor_vec         dir_lines;
        logic [HALF_W-1:0]  half_cnt;
        logic [PRESC_W-1:0] presc;
        logic [GAP_W-1:0]   gap_cnt;
        t_result            pin_frames[$];
        int                 mismatches;
        int                 checked;
        int                 solo_moves;
        int                 paired_moves;
        int                 refused;

        function new();
            half_period  = HALF_RESET;
            move_gap     = GAP_RESET;
            pend_valid   = 1'b0;
            pend_move    = '0;
            phase        = PH_IDLE;
            motor_a      = '0;
            motor_b      = '0;
            paired       = 1'b0;
            steps_a      = '0;
            steps_b      = '0;
            step_idx     = '0;
            dir_lines    = '0;
            half_cnt     = '0;
            presc        = '0;
            gap_cnt      = '0;
            mismatches   = 0;
            checked      = 0;
            solo_moves   = 0;
            paired_moves = 0;
            refused      = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DAT_W-1:0] value);
            if (idx == CFG_HALF_PERIOD)
                half_period = value;
            else if (idx == CFG_MOVE_GAP)
                move_gap = value;
        endfunction

        // letters come in groups of three per motor: U, D, L, R, F, B
        function logic [MOTOR_W-1:0] motor_of(logic [IDX_W-1:0] idx);
            case (idx / 3)
                0:       return 3'd0;
                1:       return 3'd3;
                2:       return 3'd4;
                3:       return 3'd1;
                4:       return 3'd2;
                default: return 3'd5;
            endcase
        endfunction

        function logic opposite(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
            logic [MOTOR_W-1:0] ma;
            logic [MOTOR_W-1:0] mb;
            ma = motor_of(a);
            mb = motor_of(b);
            return (ma != mb) && ((ma % 3) == (mb % 3));
        endfunction

        function void launch(logic [IDX_W-1:0] a, logic pair, logic [IDX_W-1:0] b);
            motor_a            = motor_of(a);
            steps_a            = (a % 3 == 2) ? STEPS_LONG : STEPS_SHORT;
            dir_lines[motor_a] = (a % 3 == 1);
            paired             = pair;
            if (pair) begin
                motor_b            = motor_of(b);
                steps_b            = (b % 3 == 2) ? STEPS_LONG : STEPS_SHORT;
                dir_lines[motor_b] = (b % 3 == 1);
                paired_moves++;
            end else begin
                motor_b = '0;
                steps_b = '0;
                solo_moves++;
            end
            step_idx = '0;
            half_cnt = '0;
            phase    = PH_HIGH;
        endfunction

        // one microsecond tick; returns 1 when a move finishes
        function logic advance_tick();
            logic [STEPS_W-1:0] longest;
            case (phase)
                PH_HIGH: begin
                    half_cnt = half_cnt + 1'b1;
                    if (half_cnt >= half_period) begin
                        half_cnt = '0;
                        phase    = PH_LOW;
                    end
                end
                PH_LOW: begin
                    half_cnt = half_cnt + 1'b1;
                    if (half_cnt >= half_period) begin
                        half_cnt = '0;
                        step_idx = step_idx + 1'b1;
                        longest  = (paired && steps_b > steps_a) ? steps_b : steps_a;
                        if (step_idx >= longest) begin
                            presc   = '0;
                            gap_cnt = '0;
                            if (move_gap == '0) begin
                                phase = PH_IDLE;
                                return 1'b1;
                            end
                            phase = PH_GAP;
                        end else begin
                            phase = PH_HIGH;
                        end
                    end
                end
                PH_GAP: begin
                    presc = presc + 1'b1;
                    if (presc >= PRESC_LIMIT) begin
                        presc   = '0;
                        gap_cnt = gap_cnt + 1'b1;
                    end
                    if (gap_cnt >= move_gap) begin
                        phase = PH_IDLE;
                        return 1'b1;
                    end
                end
                default: ;
            endcase
            return 1'b0;
        endfunction

        // returns 1 when the beat was a letter or end marker that got taken
        function logic take_move_beat(t_mode mode, logic [CODE_W-1:0] code);
            t_result          r;
            logic             busy;
            logic [IDX_W-1:0] idx;
            busy            = (phase != PH_IDLE);
            r               = '0;
            r.enable_n_pins = '1;
            case (mode)
                MODE_TICK: r.move_done = advance_tick();
                MODE_LETTER: begin
                    if (busy) begin
                        refused++;
                    end else begin
                        r.accepted = 1'b1;
                        if (code >= LETTER_FIRST && code <= LETTER_LAST) begin
                            idx = IDX_W'(code - LETTER_FIRST);
                            if (!pend_valid) begin
                                pend_valid = 1'b1;
                                pend_move  = idx;
                            end else if (opposite(pend_move, idx)) begin
                                launch(pend_move, 1'b1, idx);
                                pend_valid = 1'b0;
                            end else begin
                                launch(pend_move, 1'b0, '0);
                                pend_move = idx;
                            end
                        end else if (pend_valid) begin
                            // a bad byte flushes the waiting move on its own
                            launch(pend_move, 1'b0, '0);
                            pend_valid = 1'b0;
                        end
                    end
                end
                MODE_END: begin
                    if (busy) begin
                        refused++;
                    end else begin
                        r.accepted = 1'b1;
                        if (pend_valid) begin
                            launch(pend_move, 1'b0, '0);
                            pend_valid = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
            if (phase == PH_HIGH || phase == PH_LOW) begin
                r.enable_n_pins[motor_a] = 1'b0;
                if (paired)
                    r.enable_n_pins[motor_b] = 1'b0;
                if (phase == PH_HIGH) begin
                    if (step_idx < steps_a)
                        r.step_pins[motor_a] = 1'b1;
                    if (paired && step_idx < steps_b)
                        r.step_pins[motor_b] = 1'b1;
                end
            end
            r.dir_pins     = dir_lines;
            r.busy_res     = (phase != PH_IDLE);
            r.pair_pending = pend_valid;
            pin_frames.push_back(r);
            return r.accepted;
        endfunction

        function void cmp_field(string name, logic [5:0] want, logic [5:0] got);
            if (want !== got) begin
                $display("%0t: %s expected %0h got %0h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_pins(t_result got);
            t_result want;
            if (pin_frames.size() == 0) begin
                $display("%0t: result beat with nothing expected, got %0h", $time, got);
                mismatches++;
                return;
            end
            want = pin_frames.pop_front();
            checked++;
            cmp_field("step_pins", want.step_pins, got.step_pins);
            cmp_field("dir_pins", want.dir_pins, got.dir_pins);
            cmp_field("enable_n_pins", want.enable_n_pins, got.enable_n_pins);
            cmp_field("busy_res", want.busy_res, got.busy_res);
            cmp_field("accepted", want.accepted, got.accepted);
            cmp_field("pair_pending", want.pair_pending, got.pair_pending);
            cmp_field("move_done", want.move_done, got.move_done);
        endfunction
    endclass

    pin_scoreboard sb = new();

    int cmds_taken = 0;
    int beats_sent = 0;
    int burst_left = 0;
    bit move_live  = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // one move beat; the sender runs in bursts with random gaps between them
    task automatic send_move(input t_mode m, input logic [CODE_W-1:0] code);
        int gap;
        mv_if.mode      <= m;
        mv_if.move_code <= code;
        mv_if.valid     <= 1'b1;
        move_live = 1'b1;
        do @(posedge i_clk); while (!mv_if.ready);
        beats_sent++;
        if (sb.take_move_beat(m, code))
            cmds_taken++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 40);
            gap        = $urandom_range(0, 6);
            if (gap > 0) begin
                mv_if.valid <= 1'b0;
                move_live = 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // stop sending and wait for every frame to come back
    task automatic drain();
        if (move_live) begin
            mv_if.valid <= 1'b0;
            move_live = 1'b0;
        end
        while (sb.pin_frames.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // tick the current move to its end, then drain
    task automatic settle();
        while (sb.phase != PH_IDLE)
            send_move(MODE_TICK, CODE_W'($urandom_range(0, 255)));
        drain();
    endtask

    task automatic write_regs(input logic [CFG_DAT_W-1:0] half, input logic [CFG_DAT_W-1:0] gap);
        cfg_if.index <= CFG_HALF_PERIOD;
        cfg_if.data  <= half;
        cfg_if.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.write_reg(CFG_HALF_PERIOD, half);
        cfg_if.index <= CFG_MOVE_GAP;
        cfg_if.data  <= gap;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.write_reg(CFG_MOVE_GAP, gap);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic run_random(input int n_beats);
        int               goal;
        int               r;
        logic [IDX_W-1:0] idx;
        goal = beats_sent + n_beats;
        while (beats_sent < goal) begin
            r = $urandom_range(0, 99);
            if (sb.phase != PH_IDLE) begin
                if (r < 3)
                    send_move(MODE_LETTER, CODE_W'($urandom_range(0, 255)));
                else if (r < 5)
                    send_move(MODE_END, CODE_W'($urandom_range(0, 255)));
                else if (r < 6)
                    send_move(MODE_RSVD, CODE_W'($urandom_range(0, 255)));
                else
                    send_move(MODE_TICK, CODE_W'($urandom_range(0, 255)));
            end else if (r < 55) begin
                idx = IDX_W'($urandom_range(0, 17));
                // half the time offer the opposite motor so pairs really form
                if (sb.pend_valid && $urandom_range(0, 1))
                    while (!sb.opposite(sb.pend_move, idx))
                        idx = IDX_W'($urandom_range(0, 17));
                send_move(MODE_LETTER, LETTER_FIRST + CODE_W'(idx));
            end else if (r < 65) begin
                send_move(MODE_LETTER, CODE_W'($urandom_range(0, 255)));
            end else if (r < 78) begin
                send_move(MODE_END, CODE_W'($urandom_range(0, 255)));
            end else if (r < 83) begin
                send_move(MODE_RSVD, CODE_W'($urandom_range(0, 255)));
            end else begin
                send_move(MODE_TICK, CODE_W'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        mv_if.valid     = 1'b0;
        mv_if.mode      = MODE_TICK;
        mv_if.move_code = '0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = CFG_HALF_PERIOD;
        cfg_if.data     = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset register values: a move starts with 1000 us halves
        send_move(MODE_RSVD, "A");
        send_move(MODE_END, 8'h00);      // nothing pending
        send_move(MODE_LETTER, "A");
        send_move(MODE_END, 8'hff);      // flushes U on its own
        send_move(MODE_LETTER, "B");     // refused while busy
        send_move(MODE_END, 8'h00);      // refused while busy
        repeat (8) send_move(MODE_TICK, CODE_W'($urandom_range(0, 255)));
        drain();

        // zero half period cuts the running half short; a 1 ms gap follows the move
        write_regs(16'd0, 16'd1);
        settle();

        write_regs(16'd1, 16'd0);
        send_move(MODE_LETTER, "A");
        send_move(MODE_LETTER, "F");     // U with D, 50 and 100 steps
        settle();

        // largest register values; no move is started under them
        write_regs(16'hffff, 16'hffff);
        repeat (5) send_move(MODE_TICK, CODE_W'($urandom_range(0, 255)));
        send_move(MODE_RSVD, 8'hff);
        send_move(MODE_END, 8'h00);
        send_move(MODE_LETTER, "I");
        repeat (5) send_move(MODE_TICK, CODE_W'($urandom_range(0, 255)));
        settle();

        write_regs(16'd1, 16'd0);
        run_random(100);
        send_move(MODE_END, 8'h00);
        settle();
        repeat (10) @(posedge i_clk);

        $display("testbench: %0d move beats, %0d letters and end markers taken, %0d refused",
                 beats_sent, cmds_taken, sb.refused);
        $display("testbench: %0d frames checked, %0d solo and %0d paired moves",
                 sb.checked, sb.solo_moves, sb.paired_moves);
        if (sb.mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    // receiver stall pattern switches among four styles picked at random
    initial begin
        int style;
        int cnt;
        style        = 0;
        cnt          = 0;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            cnt++;
            if (cnt % 300 == 0)
                style = $urandom_range(0, 3);
            case (style)
                0:       res_if.ready <= 1'b1;
                1:       res_if.ready <= ($urandom_range(0, 9) < 7);
                2:       res_if.ready <= (cnt % 8 < 5);
                default: res_if.ready <= (cnt % 48 >= 12);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready)
            sb.check_pins(t_result'{step_pins:     res_if.step_pins,
                                    dir_pins:      res_if.dir_pins,
                                    enable_n_pins: res_if.enable_n_pins,
                                    busy_res:      res_if.busy_res,
                                    accepted:      res_if.accepted,
                                    pair_pending:  res_if.pair_pending,
                                    move_done:     res_if.move_done});
    end

    // watchdog: cycles in a row with no beat on any channel
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (mv_if.valid && mv_if.ready) || (res_if.valid && res_if.ready)
                    || (cfg_if.valid && cfg_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: timeout, no beat for %0d cycles", $time, quiet);
        $display("testbench: done, errors");
        $finish;
    end

endmodule
